### design/rbss_pkg.sv
`timescale 1ns / 1ps
package rbss_pkg;

	localparam int MaxSweeps = 16;
	localparam int EntryW    = 2 + 4 * 17 + 2 * 16;

	typedef enum logic [1:0] {
		KIND_RHI      = 2'd0,
		KIND_PPI      = 2'd1,
		KIND_INACTIVE = 2'd2,
		KIND_SPARE    = 2'd3
	} sweep_kind_t;

	typedef enum logic [1:0] {
		REG_SWEEP_COUNT = 2'd0,
		REG_BEAMS_DWELL = 2'd1,
		REG_VISITS      = 2'd2,
		REG_NONE        = 2'd3
	} reg_index_t;

	typedef enum logic [0:0] {
		OP_LOAD    = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SETUP,
		ST_DIV,
		ST_EMIT,
		ST_OUT,
		ST_ADV_RD,
		ST_ADV
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [3:0]  sweep_slot;
		logic [1:0]  sweep_kind;
		logic [16:0] min_elevation;
		logic [16:0] max_elevation;
		logic [15:0] elevation_step;
		logic [16:0] min_azimuth;
		logic [16:0] max_azimuth;
		logic [15:0] azimuth_step;
	} in_item_t;

	typedef struct packed {
		logic        valid_res;
		logic [16:0] elevation;
		logic [16:0] azimuth;
		logic [3:0]  sweep_number;
		logic [31:0] volume_number;
		logic        start_of_dwell;
		logic [16:0] beam_in_dwell;
		logic [7:0]  visit_in_beam;
		logic        scan_mode;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [16:0] el_lo;
		logic [16:0] el_hi;
		logic [15:0] el_step;
		logic [16:0] az_lo;
		logic [16:0] az_hi;
		logic [15:0] az_step;
	} entry_t;

endpackage

### design/rbss_ram.sv
`timescale 1ns / 1ps
module rbss_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### design/radar_beam_scan_sequencer.sv
`timescale 1ns / 1ps
// Radar beam scan sequencer.
// Input channel (in_valid/in_ready/in_data): a load transaction writes one
// sweep table entry and restarts the scan; a request transaction produces
// exactly one result transaction on the output channel (out_valid/
// out_ready/out_data) carrying the next beam of the scan.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
// sweep_count, beams_per_dwell and visits_per_beam; each such write restarts.
// A pending configuration transaction holds off the input channel.
// Sequence: a load is taken from the idle state and needs no further state.
// A request mid-sweep passes through the emit and advance states before
// its result is presented. A request that opens a new sweep first examines
// table entries (at most MAX_SWEEPS), a read and a check state for each,
// then runs a setup state and the two bit-serial divides. With no usable
// sweep the search wraps once over a non-empty table and a result with
// valid_res clear follows. One item is handled at a time; the table read
// port and the divider set this.
// Reset clears the scan cursor and marks every table entry inactive
// through per-entry valid bits; no clearing pass is needed.
// If the receiver stalls, the result is held and no new input is taken.
module radar_beam_scan_sequencer #(
	parameter int MAX_SWEEPS = rbss_pkg::MaxSweeps
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rbss_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rbss_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import rbss_pkg::*;

	localparam int AW = (MAX_SWEEPS > 1) ? $clog2(MAX_SWEEPS) : 1;
	localparam int CW = $clog2(MAX_SWEEPS + 1);

	state_t state_q, state_d;

	// configuration
	logic [4:0]  sweep_count_q;
	logic [15:0] bpd_q;
	logic [7:0]  vpb_q;

	// cursor
	logic [CW-1:0] cur_q;
	logic          wrapped_q;
	logic          fresh_q;
	logic signed [17:0] outer_q, inner_q;
	logic [16:0] dwell_q, beam_q;
	logic [17:0] stride_q;
	logic [7:0]  visit_q;
	logic        first_q;
	logic [31:0] vol_q;

	// divider
	logic [16:0] quo_q, rem_q, dividend_q;
	logic [4:0]  divcnt_q;

	logic [MAX_SWEEPS-1:0] vbit_q;
	logic [CW-1:0] n_use;
	entry_t  rd_ent, ent;
	logic    ent_ok;
	logic [EntryW-1:0] ram_rdata;
	logic    ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t  wr_ent;
	out_item_t res_q;
	logic    out_valid_q;

	logic in_fire, cfg_fire, load_ok;
	assign in_fire  = in_valid && in_ready;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign load_ok  = in_fire && (in_data.operation == OP_LOAD) &&
		(32'(in_data.sweep_slot) < MAX_SWEEPS);

	assign n_use = (32'(sweep_count_q) > MAX_SWEEPS) ? CW'(MAX_SWEEPS)
		: CW'(sweep_count_q);

	// table write data
	always_comb begin
		wr_ent.kind    = in_data.sweep_kind;
		wr_ent.el_lo   = in_data.min_elevation;
		wr_ent.el_hi   = in_data.max_elevation;
		wr_ent.el_step = (in_data.elevation_step == '0) ? 16'd1 : in_data.elevation_step;
		wr_ent.az_lo   = in_data.min_azimuth;
		wr_ent.az_hi   = in_data.max_azimuth;
		wr_ent.az_step = (in_data.azimuth_step == '0) ? 16'd1 : in_data.azimuth_step;
	end
	assign ram_we    = load_ok;
	assign ram_waddr = AW'(in_data.sweep_slot);
	assign ram_raddr = AW'(cur_q);

	rbss_ram #(.Width(EntryW), .Depth(MAX_SWEEPS)) u_tab (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wr_ent),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// never-written entries read as inactive
	logic vsel_q;
	always_comb begin
		rd_ent = entry_t'(ram_rdata);
		if (!vsel_q) begin
			rd_ent = '0;
			rd_ent.kind = KIND_INACTIVE;
			rd_ent.el_step = 16'd1;
			rd_ent.az_step = 16'd1;
		end
	end

	// entry latched for the current sweep
	entry_t ent_q;
	assign ent = ent_q;

	// outer / inner dimensions
	logic signed [17:0] olo, ohi, ilo, ihi;
	logic [15:0] ostep, istep;
	always_comb begin
		if (ent.kind == KIND_RHI) begin
			olo = 18'(signed'(ent.az_lo)); ohi = 18'(signed'(ent.az_hi)); ostep = ent.az_step;
			ilo = 18'(signed'(ent.el_lo)); ihi = 18'(signed'(ent.el_hi)); istep = ent.el_step;
		end else begin
			olo = 18'(signed'(ent.el_lo)); ohi = 18'(signed'(ent.el_hi)); ostep = ent.el_step;
			ilo = 18'(signed'(ent.az_lo)); ihi = 18'(signed'(ent.az_hi)); istep = ent.az_step;
		end
	end

	// has-beams check on the freshly read entry
	assign ent_ok = (rd_ent.kind == KIND_RHI || rd_ent.kind == KIND_PPI) && (vpb_q != '0) &&
		($signed(rd_ent.el_lo) <= $signed(rd_ent.el_hi)) &&
		($signed(rd_ent.az_lo) <= $signed(rd_ent.az_hi));

	// advance arithmetic (multiplies by istep, registered state)
	logic signed [35:0] inner_inc, inner_nx;
	logic signed [35:0] inner_dw;
	logic signed [18:0] outer_nx;
	logic [7:0]  visit_nx;
	logic [17:0] dwell_nx;
	assign inner_inc = $signed({1'b0, stride_q}) * $signed({1'b0, istep});
	assign inner_nx  = 36'(inner_q) + inner_inc;
	assign visit_nx  = visit_q + 8'd1;
	assign dwell_nx  = {1'b0, dwell_q} + 18'd1;
	assign inner_dw  = 36'(ilo) + $signed({1'b0, dwell_nx}) * $signed({1'b0, istep});
	assign outer_nx  = 19'(outer_q) + 19'(ostep);

	// divisor for the stride divide: first by istep, then by bpd
	logic        div_phase_q;
	logic [16:0] divisor;
	logic [17:0] trial;
	assign divisor = div_phase_q ? 17'(bpd_q == '0 ? 16'd1 : bpd_q) : 17'(istep);
	assign trial = {rem_q, dividend_q[16]} - {1'b0, divisor};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_data.operation == OP_REQUEST) begin
					state_d = fresh_q ? ST_SCAN_RD : ST_EMIT;
				end
			end
			ST_SCAN_RD: begin
				if (cur_q >= n_use) begin
					state_d = (wrapped_q || n_use == '0) ? ST_OUT : ST_SCAN_RD;
				end else begin
					state_d = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: state_d = ent_ok ? ST_SETUP : ST_SCAN_RD;
			ST_SETUP:    state_d = ST_DIV;
			ST_DIV:      state_d = (div_phase_q && divcnt_q == 5'd16) ? ST_EMIT : ST_DIV;
			ST_EMIT:     state_d = ST_ADV;
			ST_ADV:      state_d = ST_OUT;
			ST_OUT:      state_d = ST_IDLE;
			ST_ADV_RD:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sweep_count_q <= '0;
			bpd_q <= 16'd1;
			vpb_q <= 8'd1;
			cur_q <= '0;
			wrapped_q <= 1'b0;
			fresh_q <= 1'b1;
			outer_q <= '0; inner_q <= '0;
			dwell_q <= '0; beam_q <= '0; stride_q <= '0;
			visit_q <= '0; first_q <= 1'b1; vol_q <= '0;
			vbit_q <= '0;
			vsel_q <= 1'b0;
			out_valid_q <= 1'b0;
			res_q <= '0;
			ent_q <= '0;
			quo_q <= '0; rem_q <= '0; dividend_q <= '0;
			div_phase_q <= 1'b0;
			divcnt_q <= '0;
		end else begin
			state_q <= state_d;
			vsel_q <= vbit_q[ram_raddr];
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire || (in_fire && in_data.operation == OP_LOAD)) begin
				if (cfg_fire) begin
					case (reg_index_t'(cfg_index))
						REG_SWEEP_COUNT: sweep_count_q <= cfg_data[4:0];
						REG_BEAMS_DWELL: bpd_q <= cfg_data[15:0];
						REG_VISITS:      vpb_q <= cfg_data[7:0];
						default: ;
					endcase
				end
				if (load_ok) begin
					vbit_q[ram_waddr] <= 1'b1;
				end
				if (!cfg_fire || cfg_index != REG_NONE) begin
					cur_q <= '0; fresh_q <= 1'b1; vol_q <= '0;
					outer_q <= '0; inner_q <= '0; dwell_q <= '0; visit_q <= '0;
					beam_q <= '0; first_q <= 1'b1; stride_q <= '0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					wrapped_q <= 1'b0;
				end
				ST_SCAN_RD: begin
					if (cur_q >= n_use) begin
						if (!wrapped_q && n_use != '0) begin
							cur_q <= '0;
							wrapped_q <= 1'b1;
						end else begin
							cur_q <= '0;
							res_q <= '0;
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_SCAN_CHK: begin
					if (ent_ok) begin
						ent_q <= rd_ent;
						if (wrapped_q) vol_q <= vol_q + 32'd1;
					end else begin
						cur_q <= cur_q + CW'(1);
					end
				end
				ST_SETUP: begin
					outer_q <= olo; inner_q <= ilo;
					dwell_q <= '0; visit_q <= '0; beam_q <= '0; first_q <= 1'b1;
					fresh_q <= 1'b0;
					dividend_q <= 17'(ihi - ilo);
					rem_q <= '0; quo_q <= '0;
					divcnt_q <= '0; div_phase_q <= 1'b0;
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					if (divcnt_q == 5'd17) begin
						dividend_q <= quo_q; rem_q <= '0; quo_q <= '0;
						divcnt_q <= '0; div_phase_q <= 1'b1;
					end else begin
						if (!trial[17]) begin
							rem_q <= trial[16:0];
							quo_q <= {quo_q[15:0], 1'b1};
						end else begin
							rem_q <= {rem_q[15:0], dividend_q[16]};
							quo_q <= {quo_q[15:0], 1'b0};
						end
						dividend_q <= {dividend_q[15:0], 1'b0};
						divcnt_q <= divcnt_q + 5'd1;
						if (div_phase_q && divcnt_q == 5'd16) begin
							stride_q <= 18'({quo_q[15:0], !trial[17]}) + 18'd1;
						end
					end
				end
				ST_EMIT: begin
					res_q.valid_res <= 1'b1;
					res_q.elevation <= (ent.kind == KIND_RHI) ? inner_q[16:0] : outer_q[16:0];
					res_q.azimuth <= (ent.kind == KIND_RHI) ? outer_q[16:0] : inner_q[16:0];
					res_q.sweep_number <= 4'(cur_q);
					res_q.volume_number <= vol_q;
					res_q.start_of_dwell <= first_q;
					res_q.beam_in_dwell <= beam_q;
					res_q.visit_in_beam <= visit_q;
					res_q.scan_mode <= (ent.kind != KIND_RHI);
				end
				ST_ADV: begin
					out_valid_q <= 1'b1;
					first_q <= 1'b0;
					beam_q <= beam_q + 17'd1;
					inner_q <= 18'(inner_nx);
					if (inner_nx > 36'(ihi)) begin
						beam_q <= '0;
						inner_q <= 18'(inner_dw);
						visit_q <= visit_nx;
						if (visit_nx >= vpb_q) begin
							visit_q <= '0;
							dwell_q <= 17'(dwell_nx);
							first_q <= 1'b1;
							if (dwell_nx >= stride_q) begin
								dwell_q <= '0;
								inner_q <= ilo;
								outer_q <= 18'(outer_nx);
								if (outer_nx > 19'(ohi)) begin
									cur_q <= cur_q + CW'(1);
									fresh_q <= 1'b1;
								end
							end
						end else begin
							inner_q <= 18'(36'(ilo) + $signed({1'b0, dwell_q}) *
								$signed({1'b0, istep}));
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;
endmodule

### design/rbss_checker.sv
`timescale 1ns / 1ps
module rbss_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  rbss_pkg::in_item_t in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  rbss_pkg::out_item_t out_data
);
	import rbss_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// no input taken while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted with pending result");

	// an invalid result carries zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.valid_res |-> out_data.volume_number == '0 &&
		out_data.elevation == '0 && out_data.azimuth == '0)
		else $error("no-angle result not zero");

	// a load makes no result
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.operation == OP_LOAD |=> !out_valid)
		else $error("load produced a result");
endmodule

bind radar_beam_scan_sequencer rbss_checker u_rbss_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
	.out_data(out_data)
);

### dv/radar_beam_scan_sequencer_test.sv
`timescale 1ns / 1ps
module radar_beam_scan_sequencer_test;
	import rbss_pkg::*;

	// Beam sequence predictor and store of expected beams
	class beam_scoreboard;
		logic [1:0] kinds [MaxSweeps];
		int el_lo [MaxSweeps], el_hi [MaxSweeps], az_lo [MaxSweeps], az_hi [MaxSweeps];
		int unsigned el_step [MaxSweeps], az_step [MaxSweeps];
		int unsigned sweep_count, beams_dwell, visits;
		int unsigned cur_sweep, dwell_idx, visit_idx, beam_cnt, stride;
		longint outer_ang, inner_ang;
		bit first_dwell, fresh;
		logic [31:0] volume;
		out_item_t expected_beams [$];
		int errors;

		function new();
			for (int i = 0; i < MaxSweeps; i++) begin
				kinds[i] = KIND_INACTIVE;
				el_lo[i] = 0; el_hi[i] = 0; az_lo[i] = 0; az_hi[i] = 0;
				el_step[i] = 1; az_step[i] = 1;
			end
			sweep_count = 0;
			beams_dwell = 1;
			visits = 1;
			errors = 0;
			restart();
		endfunction

		function void restart();
			cur_sweep = 0; outer_ang = 0; inner_ang = 0;
			dwell_idx = 0; visit_idx = 0; beam_cnt = 0;
			first_dwell = 1; stride = 0; volume = 0; fresh = 1;
		endfunction

		function void write_reg(reg_index_t idx, logic [31:0] data);
			case (idx)
				REG_SWEEP_COUNT: sweep_count = data[4:0];
				REG_BEAMS_DWELL: beams_dwell = data[15:0];
				REG_VISITS:      visits = data[7:0];
				default: return;
			endcase
			restart();
		endfunction

		function bit has_beams(int unsigned s);
			if (s >= MaxSweeps) return 0;
			if (kinds[s] > KIND_PPI || visits == 0) return 0;
			return el_lo[s] <= el_hi[s] && az_lo[s] <= az_hi[s];
		endfunction

		// RHI: azimuth outside, elevation inside; otherwise swapped
		function void dims(int unsigned s, output int olo, output int ohi,
			output int unsigned ostep, output int ilo, output int ihi,
			output int unsigned istep);
			if (kinds[s] == KIND_RHI) begin
				olo = az_lo[s]; ohi = az_hi[s]; ostep = az_step[s];
				ilo = el_lo[s]; ihi = el_hi[s]; istep = el_step[s];
			end else begin
				olo = el_lo[s]; ohi = el_hi[s]; ostep = el_step[s];
				ilo = az_lo[s]; ihi = az_hi[s]; istep = az_step[s];
			end
		endfunction

		function void open_sweep(int unsigned s);
			int olo, ohi, ilo, ihi;
			int unsigned ostep, istep, bpd;
			dims(s, olo, ohi, ostep, ilo, ihi, istep);
			bpd = beams_dwell ? beams_dwell : 1;
			stride = (unsigned'(ihi - ilo) / istep) / bpd + 1;
			cur_sweep = s; outer_ang = olo; inner_ang = ilo;
			dwell_idx = 0; visit_idx = 0; beam_cnt = 0;
			first_dwell = 1; fresh = 0;
		endfunction

		function void step_beam();
			int olo, ohi, ilo, ihi;
			int unsigned ostep, istep;
			dims(cur_sweep, olo, ohi, ostep, ilo, ihi, istep);
			first_dwell = 0;
			beam_cnt++;
			inner_ang += longint'(stride) * longint'(istep);
			if (inner_ang <= ihi) return;
			beam_cnt = 0;
			visit_idx++;
			if (visit_idx >= visits) begin
				visit_idx = 0;
				dwell_idx++;
				first_dwell = 1;
				if (dwell_idx >= stride) begin
					dwell_idx = 0;
					outer_ang += ostep;
					if (outer_ang > ohi) begin
						cur_sweep++;
						fresh = 1;
						return;
					end
				end
			end
			inner_ang = longint'(ilo) + longint'(dwell_idx) * longint'(istep);
		endfunction

		// Accepted input transaction
		function void note_item(in_item_t it);
			out_item_t r;
			int unsigned n, s;
			bit found;
			int sl;
			if (it.operation == OP_LOAD) begin
				sl = it.sweep_slot;
				kinds[sl] = it.sweep_kind;
				el_lo[sl] = $signed(it.min_elevation);
				el_hi[sl] = $signed(it.max_elevation);
				el_step[sl] = it.elevation_step ? it.elevation_step : 1;
				az_lo[sl] = $signed(it.min_azimuth);
				az_hi[sl] = $signed(it.max_azimuth);
				az_step[sl] = it.azimuth_step ? it.azimuth_step : 1;
				restart();
				return;
			end
			r = '0;
			n = sweep_count > MaxSweeps ? MaxSweeps : sweep_count;
			if (fresh) begin
				found = 0;
				for (s = cur_sweep; s < n; s++)
					if (has_beams(s)) begin found = 1; break; end
				if (!found) begin
					for (s = 0; s < n; s++)
						if (has_beams(s)) begin found = 1; break; end
					if (!found) begin
						cur_sweep = 0;
						expected_beams.insert(expected_beams.size(), r);
						return;
					end
					volume++;
				end
				open_sweep(s);
			end
			r.valid_res = 1;
			r.elevation = kinds[cur_sweep] == KIND_RHI ? inner_ang[16:0] : outer_ang[16:0];
			r.azimuth = kinds[cur_sweep] == KIND_RHI ? outer_ang[16:0] : inner_ang[16:0];
			r.sweep_number = cur_sweep[3:0];
			r.volume_number = volume;
			r.start_of_dwell = first_dwell;
			r.beam_in_dwell = beam_cnt[16:0];
			r.visit_in_beam = visit_idx[7:0];
			r.scan_mode = kinds[cur_sweep] != KIND_RHI;
			expected_beams.insert(expected_beams.size(), r);
			step_beam();
		endfunction

		function void cmp(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
				errors++;
			end
		endfunction

		// Accepted result transaction
		function void check_beam(out_item_t a);
			out_item_t e;
			if (expected_beams.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, a);
				errors++;
				return;
			end
			e = expected_beams.pop_front();
			cmp("valid_res", e.valid_res, a.valid_res);
			cmp("elevation", e.elevation, a.elevation);
			cmp("azimuth", e.azimuth, a.azimuth);
			cmp("sweep_number", e.sweep_number, a.sweep_number);
			cmp("volume_number", e.volume_number, a.volume_number);
			cmp("start_of_dwell", e.start_of_dwell, a.start_of_dwell);
			cmp("beam_in_dwell", e.beam_in_dwell, a.beam_in_dwell);
			cmp("visit_in_beam", e.visit_in_beam, a.visit_in_beam);
			cmp("scan_mode", e.scan_mode, a.scan_mode);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	in_item_t in_data = '0;
	logic out_valid, out_ready = 0;
	out_item_t out_data;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = REG_NONE;
	logic [31:0] cfg_data = '0;

	beam_scoreboard sb = new();
	int send_idle_pct = 0, recv_stall_pct = 0;
	int hold_cycles = 0;
	int unsigned cycles = 0;

	radar_beam_scan_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Transaction monitors
	always @(posedge clk) begin
		if (in_valid && in_ready) sb.note_item(in_data);
		if (out_valid && out_ready) sb.check_beam(out_data);
		if (cfg_valid && cfg_ready) sb.write_reg(reg_index_t'(cfg_index), cfg_data);
	end

	// Receiver with random stalls and an occasional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else begin
			out_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("radar_beam_scan_sequencer regression: fail");
			$finish;
		end
	end

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.expected_beams.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		in_valid <= 0;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic in_item_t make_load(int slot, logic [1:0] kind, int el0, int el1,
		int es, int az0, int az1, int as);
		in_item_t it;
		it.operation = OP_LOAD;
		it.sweep_slot = 4'(slot);
		it.sweep_kind = kind;
		it.min_elevation = 17'(el0);
		it.max_elevation = 17'(el1);
		it.elevation_step = 16'(es);
		it.min_azimuth = 17'(az0);
		it.max_azimuth = 17'(az1);
		it.azimuth_step = 16'(as);
		return it;
	endfunction

	// Random sweep: mostly small ranges, sometimes inverted, wide or inactive
	function automatic in_item_t random_load();
		int el0, az0, sel;
		logic [1:0] kind;
		sel = $urandom_range(99);
		kind = sel < 45 ? KIND_RHI : sel < 90 ? KIND_PPI : 2'($urandom_range(2, 3));
		el0 = $urandom_range(72000) - 36000;
		az0 = $urandom_range(72000) - 36000;
		if ($urandom_range(19) == 0)
			return make_load($urandom_range(15), kind, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
		return make_load($urandom_range(15), kind, el0,
			el0 + $urandom_range(400) - ($urandom_range(9) == 0 ? 450 : 0),
			$urandom_range(3) == 0 ? 0 : $urandom_range(1, 150),
			az0, az0 + $urandom_range(400) - ($urandom_range(9) == 0 ? 450 : 0),
			$urandom_range(3) == 0 ? 0 : $urandom_range(1, 150));
	endfunction

	function automatic in_item_t request_item();
		in_item_t it;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.operation = OP_REQUEST;
		return it;
	endfunction

	task automatic configure(int count, int bpd, int vis);
		write_reg(REG_SWEEP_COUNT, (count & 32'h1F) | ($urandom & ~32'h1F));
		write_reg(REG_BEAMS_DWELL, (bpd & 32'hFFFF) | ($urandom & ~32'hFFFF));
		write_reg(REG_VISITS, (vis & 32'hFF) | ($urandom & ~32'hFF));
	endtask

	task automatic random_phase(int items);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(99) < 8) begin
				send_item(random_load());
				// refill the table a little after each load
				if ($urandom_range(1)) send_item(random_load());
			end else begin
				send_item(request_item());
			end
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty table, extremes, zero steps, inverted and inactive sweeps
		send_item(request_item());
		configure(4, 2, 2);
		send_item(request_item());
		send_item(make_load(0, KIND_RHI, -36000, 36000, 36000, -36000, 36000, 36000));
		send_item(make_load(1, KIND_PPI, 10, 12, 0, -5, 3, 0));
		send_item(make_load(2, KIND_INACTIVE, 0, 10, 1, 0, 10, 1));
		send_item(make_load(3, KIND_SPARE, 0, 10, 1, 0, 10, 1));
		send_item(make_load(15, KIND_RHI, 5, 0, 1, 0, 5, 1));
		for (int i = 0; i < 18; i++) send_item(request_item());
		send_item(make_load(2, KIND_RHI, 100, 99, 1, 0, 5, 1));
		send_item(request_item());
		drain();
		write_reg(REG_NONE, $urandom);
		send_item(request_item());
		drain();

		// Phase 1: no idling, plain dwells, long receiver hold-off
		configure(6, 1, 1);
		for (int i = 0; i < 6; i++) send_item(random_load());
		fork
			begin
				repeat (20) @(posedge clk);
				hold_cycles = 400;
			end
			random_phase(200);
		join

		// Phase 2: sender idles, full table, widest divisor, most visits
		send_idle_pct = 63;
		configure(16, 65535, 255);
		for (int i = 0; i < 16; i++) send_item(random_load());
		random_phase(200);

		// Phase 3: receiver stalls, oversized count, zero divisor, no visits then two
		send_idle_pct = 0;
		recv_stall_pct = 63;
		configure(31, 0, 0);
		random_phase(30);
		configure(31, 0, 2);
		for (int i = 0; i < 10; i++) send_item(random_load());
		random_phase(180);

		// Phase 4: both idle, zero count then a small table
		send_idle_pct = 14;
		recv_stall_pct = 14;
		configure(0, 3, 1);
		random_phase(20);
		configure(3, 3, 3);
		for (int i = 0; i < 3; i++) send_item(random_load());
		random_phase(140);

		if (sb.errors == 0 && sb.expected_beams.size() == 0)
			$display("radar_beam_scan_sequencer regression: pass");
		else
			$display("radar_beam_scan_sequencer regression: fail");
		$finish;
	end
endmodule
